>>> rtl/gww_pkg.sv
// Shared types and constants for the greedy word wrap block.
// Used by the channel interfaces, the glyph table and the top level.
package gww_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MAX_WORD_DEF   = 32;
  localparam int CODE_COUNT_DEF = 256;

  // Field widths
  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int ADV_W     = 8;
  localparam int SUM_W     = 24;
  localparam int MAXW_W    = 16;
  localparam int GAP_W     = 8;
  localparam int SCALE_W   = 12;
  localparam int FRAC_W    = 8;
  localparam int PROD_W    = ADV_W + SCALE_W;
  localparam int SCALED_W  = PROD_W - FRAC_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Request types
  localparam logic [REQ_W-1:0] REQ_TEXT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_END   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GLYPH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  // Configuration reset values
  localparam logic [MAXW_W-1:0]  MAXW_RST  = 16'hFFFF;
  localparam logic [GAP_W-1:0]   GAP_RST   = 8'd2;
  localparam logic [SCALE_W-1:0] SCALE_RST = 12'd256;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_EOT = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SP  = 8'd32;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_CHK,
    S_NL,
    S_WORD,
    S_TAIL
  } state_t;

  // Kind of the request in flight
  typedef enum logic [1:0] {
    K_CHAR,
    K_WS,
    K_EOT
  } kind_t;

  // Glyph table write and read data
  typedef struct packed {
    logic              en;
    logic [CHAR_W-1:0] code;
    logic              present;
    logic [ADV_W-1:0]  advance;
  } glyph_wr_t;

  typedef struct packed {
    logic             present;
    logic [ADV_W-1:0] advance;
  } glyph_rd_t;

endpackage

>>> rtl/gww_in_if.sv
// Input request channel of the word wrap block: valid/ready plus request fields.
// Depends on gww_pkg for field widths.
interface gww_in_if;
  import gww_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic              glyph_present;
  logic [ADV_W-1:0]  glyph_advance;

  modport source (
    output valid, req_type, char_code, glyph_present, glyph_advance,
    input  ready
  );

  modport sink (
    input  valid, req_type, char_code, glyph_present, glyph_advance,
    output ready
  );
endinterface

>>> rtl/gww_out_if.sv
// Result channel of the word wrap block: valid/ready plus emitted character.
// Depends on gww_pkg for field widths.
interface gww_out_if;
  import gww_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              run_last;
  logic              text_done;

  modport source (
    output valid, out_char, run_last, text_done,
    input  ready
  );

  modport sink (
    input  valid, out_char, run_last, text_done,
    output ready
  );
endinterface

>>> rtl/gww_glyph_tab.sv
// Glyph table: present flag and advance per character code, registered read.
// Per-entry valid bits make unwritten entries read as absent. Uses gww_pkg.
module gww_glyph_tab #(
  parameter int CODE_COUNT = gww_pkg::CODE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gww_pkg::glyph_wr_t         wr,
  input  logic [gww_pkg::CHAR_W-1:0] rd_code,
  output gww_pkg::glyph_rd_t         rd
);
  import gww_pkg::*;

  localparam int CIDX_W = $clog2(CODE_COUNT);

  logic [CODE_COUNT-1:0] vld_r;
  logic [ADV_W:0]        mem [CODE_COUNT];
  logic [ADV_W:0]        rdata_r;
  logic                  rvld_r;
  logic [CIDX_W-1:0]     wr_idx;
  logic [CIDX_W-1:0]     rd_idx;

  assign wr_idx = wr.code[CIDX_W-1:0];
  assign rd_idx = rd_code[CIDX_W-1:0];

  // Mark entries as written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  // Write and read the table storage
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= {wr.present, wr.advance};
    end
    rdata_r <= mem[rd_idx];
    rvld_r  <= vld_r[rd_idx];
  end

  assign rd.present = rvld_r & rdata_r[ADV_W];
  assign rd.advance = rdata_r[ADV_W-1:0];

endmodule

>>> rtl/greedy_word_wrap.sv
// Greedy word wrap. Takes text one character per request on in_ch and emits
// the wrapped text on out_ch, inserting a newline ahead of a word that would
// push the line past max_line_width.
// Requests: text character, end of text, or a glyph table write. The config
// port (cfg_we/cfg_idx/cfg_wdata) sets max_line_width, word_gap and scale_q8.
// Sequencing: one request at a time under a small sequencer. A glyph write
// is done on acceptance. A word character goes through table read, scale
// multiply and width add; the one that fills the buffer adds the wrap check
// and the flush. A whitespace request goes through table read, scale multiply
// and wrap check, then emits in turn an optional newline, the buffered word
// and the whitespace itself. End of text skips the multiply. One multiplier
// and the single shared adder serve all steps; the word buffer is read one
// character per cycle: one result per cycle while the receiver keeps up.
// Results go through a one-entry output register; a stalled receiver holds
// the sequencer at the current emission until the register frees up.
// Reset: registers take their reset values, line and word are empty, and all
// glyph table entries read as absent at once (no clearing pass).
// Files: gww_pkg, gww_in_if, gww_out_if, gww_glyph_tab.
module greedy_word_wrap #(
  parameter int MAX_WORD   = gww_pkg::MAX_WORD_DEF,
  parameter int CODE_COUNT = gww_pkg::CODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gww_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gww_pkg::CFG_W-1:0]     cfg_wdata,
  gww_in_if.sink                        in_ch,
  gww_out_if.source                     out_ch
);
  import gww_pkg::*;

  localparam int LEN_W  = $clog2(MAX_WORD + 1);
  localparam int AW     = $clog2(MAX_WORD);
  localparam int SUMX_W = SUM_W + 1;

  // Configuration registers
  logic [MAXW_W-1:0]  maxw_r;
  logic [GAP_W-1:0]   gap_r;
  logic [SCALE_W-1:0] scale_r;

  // Sequencer and running sums
  state_t             state_r, state_nxt;
  logic [SUM_W-1:0]   line_r, line_nxt;
  logic [SUM_W-1:0]   word_r, word_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;

  // Request in flight
  logic [CHAR_W-1:0]   code_r;
  kind_t               kind_r, kind_nxt;
  logic                inr_r;
  logic [SCALED_W-1:0] adv_r, adv_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic              run_last_r;
  logic              text_done_r;

  // Emission request from the sequencer
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic              emit_done;
  logic              out_free;

  logic              in_fire;
  logic              in_range;
  logic              is_ws;
  glyph_wr_t         gwr;
  glyph_rd_t         grd;

  logic [ADV_W-1:0]  base;
  logic [PROD_W-1:0] prod;

  logic [SUM_W-1:0]  add_a, add_b, add_sat;
  logic [SUMX_W-1:0] add_sum;
  logic              over;

  logic [CHAR_W-1:0] word_mem [MAX_WORD];
  logic [CHAR_W-1:0] ws_rdata_r;
  logic              ws_we;
  logic              ws_rd_ok;
  logic [LEN_W-1:0]  len_inc;
  logic [LEN_W-1:0]  len_new;
  logic [LEN_W-1:0]  idx_inc;
  logic              word_last;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign in_range    = {1'b0, in_ch.char_code} < (CHAR_W + 1)'(CODE_COUNT);
  assign is_ws       = (in_ch.char_code == CH_SP) || (in_ch.char_code == CH_TAB) ||
                       (in_ch.char_code == CH_NL);
  assign out_free    = !out_valid_r || out_ch.ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxw_r  <= MAXW_RST;
      gap_r   <= GAP_RST;
      scale_r <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MAX_LINE: maxw_r  <= cfg_wdata[MAXW_W-1:0];
        CFG_WORD_GAP: gap_r   <= cfg_wdata[GAP_W-1:0];
        CFG_SCALE:    scale_r <= cfg_wdata[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  // Glyph table, written by glyph requests, read at every incoming code
  assign gwr.en      = in_fire && (in_ch.req_type == REQ_GLYPH) && in_range;
  assign gwr.code    = in_ch.char_code;
  assign gwr.present = in_ch.glyph_present;
  assign gwr.advance = in_ch.glyph_advance;

  gww_glyph_tab #(
    .CODE_COUNT (CODE_COUNT)
  ) u_glyph_tab (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (gwr),
    .rd_code (in_ch.char_code),
    .rd      (grd)
  );

  // Scale the advance: one multiply, result truncated to whole units
  assign base    = (inr_r && grd.present) ? grd.advance : gap_r;
  assign prod    = {{SCALE_W{1'b0}}, base} * {{ADV_W{1'b0}}, scale_r};
  assign adv_nxt = (state_r == S_MUL) ? prod[PROD_W-1:FRAC_W] : adv_r;

  // Shared adder: word+advance, line+word, or line+advance, saturating
  assign add_a   = (state_r == S_ADD) ? word_r : line_r;
  assign add_b   = ((state_r == S_ADD) || (state_r == S_TAIL)) ? SUM_W'(adv_r) : word_r;
  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign add_sat = add_sum[SUM_W] ? {SUM_W{1'b1}} : add_sum[SUM_W-1:0];
  assign over    = add_sum > SUMX_W'(maxw_r);

  // Word buffer indexing
  assign ws_we     = (state_r == S_ADD) && (len_r < LEN_W'(MAX_WORD));
  assign len_inc   = len_r + LEN_W'(1);
  assign len_new   = ws_we ? len_inc : len_r;
  assign idx_inc   = idx_r + LEN_W'(1);
  assign word_last = (idx_inc == len_r);
  assign ws_rd_ok  = idx_nxt < LEN_W'(MAX_WORD);

  // Word buffer: write the new character, prefetch the next one to emit
  always_ff @(posedge clk) begin
    if (ws_we) begin
      word_mem[len_r[AW-1:0]] <= code_r;
    end
    if (ws_rd_ok) begin
      ws_rdata_r <= word_mem[idx_nxt[AW-1:0]];
    end
  end

  // Classify an accepted text request
  always_comb begin
    if ((in_ch.req_type == REQ_END) || (in_ch.char_code == CH_EOT)) begin
      kind_nxt = K_EOT;
    end else if (is_ws) begin
      kind_nxt = K_WS;
    end else begin
      kind_nxt = K_CHAR;
    end
  end

  // Next state and emissions
  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    word_nxt  = word_r;
    len_nxt   = len_r;
    idx_nxt   = '0;
    emit      = 1'b0;
    emit_char = CH_EOT;
    emit_last = 1'b0;
    emit_done = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.req_type)
            REQ_TEXT, REQ_END: begin
              state_nxt = (kind_nxt == K_EOT) ? S_CHK : S_MUL;
            end
            default: ;
          endcase
        end
      end

      S_MUL: begin
        state_nxt = (kind_r == K_CHAR) ? S_ADD : S_CHK;
      end

      // Add a character to the word; flush it once the buffer is full
      S_ADD: begin
        len_nxt   = len_new;
        word_nxt  = add_sat;
        state_nxt = (len_new >= LEN_W'(MAX_WORD)) ? S_CHK : S_IDLE;
      end

      // Decide on a wrap ahead of the buffered word
      S_CHK: begin
        if (len_r == '0) begin
          state_nxt = (kind_r == K_CHAR) ? S_IDLE : S_TAIL;
        end else if (over) begin
          state_nxt = S_NL;
        end else begin
          state_nxt = S_WORD;
        end
      end

      S_NL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_NL;
          line_nxt  = '0;
          state_nxt = S_WORD;
        end
      end

      // Emit the buffered word one character per cycle while out_free holds
      S_WORD: begin
        idx_nxt = idx_r;
        if (out_free) begin
          emit      = 1'b1;
          emit_char = ws_rdata_r;
          if (word_last) begin
            emit_last = (kind_r == K_CHAR);
            line_nxt  = add_sat;
            len_nxt   = '0;
            word_nxt  = '0;
            state_nxt = (kind_r == K_CHAR) ? S_IDLE : S_TAIL;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end

      // Emit the whitespace or the terminator, then settle the line width
      S_TAIL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (kind_r == K_EOT) begin
            emit_char = CH_EOT;
            emit_done = 1'b1;
            line_nxt  = '0;
            len_nxt   = '0;
            word_nxt  = '0;
          end else begin
            emit_char = code_r;
            line_nxt  = (code_r == CH_NL) ? '0 : add_sat;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold a result until the receiver takes it
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      line_r      <= '0;
      word_r      <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_r      <= line_nxt;
      word_r      <= word_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      code_r <= in_ch.char_code;
      kind_r <= kind_nxt;
      inr_r  <= in_range;
    end
    adv_r <= adv_nxt;
    if (emit) begin
      out_char_r  <= emit_char;
      run_last_r  <= emit_last;
      text_done_r <= emit_done;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_char  = out_char_r;
  assign out_ch.run_last  = run_last_r;
  assign out_ch.text_done = text_done_r;

endmodule
